// File: hdl/fmr_pkg.sv
// Package for the custom-format float multiplier: format constants and rounding mode codes.
// Has no dependencies; used by float_multiplier_round_modes.
`default_nettype none
package fmr_pkg;
	localparam int FloatBits = 32;
	localparam int ManBits = 23;
	localparam int WordBits = 32;
	localparam int ModeBits = 3;

	typedef enum logic [ModeBits-1:0] {
		RND_TRUNC     = 3'd0,
		RND_SIGN_STKY = 3'd1,
		RND_HALF_UP   = 3'd2,
		RND_G_AND_R   = 3'd3,
		RND_INF       = 3'd4,
		RND_ZERO      = 3'd5,
		RND_EVEN      = 3'd6,
		RND_ODD       = 3'd7
	} rnd_sel_t;
endpackage
`default_nettype wire

// File: hdl/float_multiplier_round_modes.sv
// Multiplier for a custom float format (hidden one, no specials) with eight rounding modes.
// Depends on fmr_pkg for format defaults and rounding mode codes.
// Throughput: one beat per cycle unless m_tready stalls the output; stage 1 registers the
// mantissa product, stage 2 normalizes, rounds and holds the result in the output register.
// Reset: arst_n clears the valid flags and sets the rounding mode register to truncate.
`default_nettype none
module float_multiplier_round_modes #(
	parameter int FLOAT_BITS = fmr_pkg::FloatBits,
	parameter int MAN_BITS = fmr_pkg::ManBits
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [fmr_pkg::ModeBits-1:0] cfg_data,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [63:0] s_tdata,   // operand_x [31:0], operand_y [63:32]
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [31:0]      m_tdata    // product [31:0]
);
	import fmr_pkg::*;

	localparam int EB = FLOAT_BITS - MAN_BITS - 1;
	localparam int MW = MAN_BITS + 1;
	localparam int PW = 2 * MW;

	rnd_sel_t mode_q;
	logic [FLOAT_BITS-1:0] x, y;
	logic [FLOAT_BITS-2:0] zero_code;
	logic v_s1, v_s2;
	logic s_s1, z_s1;
	logic [EB-1:0] e_s1;
	logic [PW-1:0] p_s1;
	logic [FLOAT_BITS-1:0] res_s2;
	logic adv1, adv2;

	assign cfg_ready = 1'b1;
	assign x = s_tdata[FLOAT_BITS-1:0];
	assign y = s_tdata[WordBits +: FLOAT_BITS];
	assign zero_code = {1'b1, {(FLOAT_BITS-2){1'b0}}};

	assign adv2 = v_s1 && (!v_s2 || m_tready);
	assign adv1 = !v_s1 || adv2;
	assign s_tready = adv1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= RND_TRUNC;
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (cfg_valid) mode_q <= rnd_sel_t'(cfg_data);
			if (adv1) v_s1 <= s_tvalid;
			if (adv2) v_s2 <= 1'b1;
			else if (m_tready) v_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv1 && s_tvalid) begin
			s_s1 <= x[FLOAT_BITS-1] ^ y[FLOAT_BITS-1];
			z_s1 <= (x[FLOAT_BITS-2:0] == zero_code) || (y[FLOAT_BITS-2:0] == zero_code);
			e_s1 <= x[MAN_BITS +: EB] + y[MAN_BITS +: EB];
			p_s1 <= PW'({1'b1, x[MAN_BITS-1:0]}) * PW'({1'b1, y[MAN_BITS-1:0]});
		end
	end

	// Normalize by one place and round.
	logic hi, ulp, g, r, inc;
	logic [MAN_BITS-1:0] mt;
	logic [MW-1:0] mr;
	logic [EB-1:0] ez;
	always_comb begin
		hi = p_s1[PW-1];
		if (hi) begin
			ulp = p_s1[MW];
			g = p_s1[MAN_BITS];
			r = |p_s1[MAN_BITS-1:0];
			mt = p_s1[MW +: MAN_BITS];
		end else begin
			ulp = p_s1[MAN_BITS];
			g = p_s1[MAN_BITS-1];
			r = (MAN_BITS > 1) ? |(p_s1[MAN_BITS-1:0] & ~(MAN_BITS'(1) << (MAN_BITS-1))) : 1'b0;
			mt = p_s1[MAN_BITS +: MAN_BITS];
		end
		unique case (mode_q)
			RND_TRUNC:     inc = 1'b0;
			RND_SIGN_STKY: inc = s_s1 & (g | r);
			RND_HALF_UP:   inc = g;
			RND_G_AND_R:   inc = g & r;
			RND_INF:       inc = g & (~s_s1 | r);
			RND_ZERO:      inc = g & (s_s1 | r);
			RND_EVEN:      inc = g & (ulp | r);
			default:       inc = g & (~ulp | r);
		endcase
		mr = {1'b0, mt} + MW'(inc);
		ez = e_s1 + EB'(hi) + EB'(mr[MAN_BITS]);
	end

	always_ff @(posedge clk) begin
		if (adv2) begin
			if (z_s1) res_s2 <= {s_s1, 1'b1, {(FLOAT_BITS-2){1'b0}}};
			else res_s2 <= {s_s1, ez, mr[MAN_BITS-1:0]};
		end
	end

	assign m_tvalid = v_s2;
	assign m_tdata = 32'(res_s2);

`ifndef SYNTHESIS
	a_in_to_s1: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> v_s1)
		else $error("accepted beat lost in stage 1");
	a_hold_out: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");
	a_s1_stall: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && !adv2 |=> v_s1 && $stable(p_s1))
		else $error("stage 1 overwritten while stalled");
`endif
endmodule
`default_nettype wire
